@@ src/bltc_pkg.sv @@
`timescale 1ns / 1ps

package bltc_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNC     = 2'd1,
        ST_UNMAPPED  = 2'd2
    } t_status;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_dir;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_last;
        t_status    status;
    } t_result;

    // results produced by one item as it leaves the input register
    typedef struct packed {
        logic    one;
        logic    two;
        t_result r0;
        t_result r1;
    } t_emit;

    function automatic logic maps_to_self(input logic [7:0] b);
        return (b >= 8'h21 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hAC) || (b >= 8'hAE);
    endfunction

    function automatic logic [8:0] byte_to_cp(input logic [7:0] b);
        logic [7:0] d;
        d = b - 8'h5E;
        if (maps_to_self(b)) begin
            return {1'b0, b};
        end else if (b <= 8'h20) begin
            return {1'b1, b};
        end else if (b <= 8'hA0) begin
            return {1'b1, d};
        end else begin
            return 9'h143;
        end
    endfunction

    function automatic logic [2:0] lead_width(input logic [7:0] b);
        if (!b[7]) begin
            return 3'd1;
        end else if (b[7:5] == 3'b110) begin
            return 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            return 3'd3;
        end else begin
            return 3'd4;
        end
    endfunction

endpackage

@@ src/bltc_if.sv @@
`timescale 1ns / 1ps

interface bltc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface bltc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output run_last, output text_last,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input run_last, input text_last,
                    input status, output ready);
endinterface

@@ src/bltc_xlate.sv @@
`timescale 1ns / 1ps

module bltc_xlate (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    bltc_in_if.sink              i_in,
    input  logic                 i_slot_free,
    output bltc_pkg::t_emit      o_emit
);

    logic                r_s1_valid;
    logic [7:0]          r_byte;
    logic                r_last;
    bltc_pkg::t_dir      r_dir;
    logic [7:0]          r_pend0, n_pend0;
    logic [7:0]          r_pend1, n_pend1;
    logic [2:0]          r_width, n_width;
    logic [2:0]          r_seen, n_seen;
    logic                r_disc, n_disc;

    logic                has_res;
    logic                move;
    bltc_pkg::t_emit     emit;

    logic [2:0]          w;
    logic [7:0]          p0, p1;
    logic [2:0]          seen_inc;
    logic [10:0]         cp2;
    logic [6:0]          n_idx;
    logic                map_ok;
    logic [7:0]          map_byte;
    logic [8:0]          ecp;

    always_comb begin
        ecp      = bltc_pkg::byte_to_cp(r_byte);
        w        = (r_seen == 3'd0) ? bltc_pkg::lead_width(r_byte) : r_width;
        p0       = (r_seen == 3'd0) ? r_byte : r_pend0;
        p1       = (r_seen == 3'd1) ? r_byte : r_pend1;
        seen_inc = r_seen + 3'd1;
        cp2      = {p0[4:0], p1[5:0]};
        n_idx    = cp2[6:0];
        map_ok   = 1'b0;
        map_byte = 8'h00;
        if (w == 3'd1) begin
            map_ok   = bltc_pkg::maps_to_self(p0);
            map_byte = p0;
        end else if (w == 3'd2 && p1[7:6] == 2'b10) begin
            if (cp2[10:8] == 3'd0 && cp2[7]) begin
                map_ok   = bltc_pkg::maps_to_self(cp2[7:0]);
                map_byte = cp2[7:0];
            end else if (cp2[10:8] == 3'd1 && cp2[7:0] <= 8'h43) begin
                map_ok = 1'b1;
                if (n_idx <= 7'd32) begin
                    map_byte = {1'b0, n_idx};
                end else if (n_idx <= 7'd66) begin
                    map_byte = {1'b0, n_idx} + 8'h5E;
                end else begin
                    map_byte = 8'hAD;
                end
            end
        end

        emit    = '0;
        n_pend0 = r_pend0;
        n_pend1 = r_pend1;
        n_width = r_width;
        n_seen  = r_seen;
        n_disc  = r_disc;

        if (r_dir == bltc_pkg::DIR_ENCODE) begin
            emit.one = 1'b1;
            if (ecp[8:7] == 2'b00) begin
                emit.r0 = '{out_byte: ecp[7:0], run_last: 1'b1, text_last: r_last,
                            status: bltc_pkg::ST_OK};
            end else begin
                emit.two = 1'b1;
                emit.r0  = '{out_byte: {5'b11000, ecp[8:6]}, run_last: 1'b0,
                             text_last: 1'b0, status: bltc_pkg::ST_OK};
                emit.r1  = '{out_byte: {2'b10, ecp[5:0]}, run_last: 1'b1,
                             text_last: r_last, status: bltc_pkg::ST_OK};
            end
        end else if (r_disc) begin
            if (r_last) begin
                n_disc = 1'b0;
            end
        end else if (seen_inc >= w) begin
            emit.one = 1'b1;
            n_pend0  = 8'h00;
            n_pend1  = 8'h00;
            n_width  = 3'd0;
            n_seen   = 3'd0;
            if (map_ok) begin
                emit.r0 = '{out_byte: map_byte, run_last: 1'b1, text_last: r_last,
                            status: bltc_pkg::ST_OK};
            end else begin
                emit.r0 = '{out_byte: 8'h00, run_last: 1'b1, text_last: 1'b1,
                            status: bltc_pkg::ST_UNMAPPED};
                n_disc  = !r_last;
            end
        end else if (r_last) begin
            emit.one = 1'b1;
            emit.r0  = '{out_byte: 8'h00, run_last: 1'b1, text_last: 1'b1,
                         status: bltc_pkg::ST_TRUNC};
            n_pend0  = 8'h00;
            n_pend1  = 8'h00;
            n_width  = 3'd0;
            n_seen   = 3'd0;
        end else begin
            n_pend0 = p0;
            n_pend1 = p1;
            n_width = w;
            n_seen  = seen_inc;
        end

        has_res = emit.one;
        move    = r_s1_valid && (!has_res || i_slot_free);
    end

    assign i_in.ready = !r_s1_valid || move;

    always_comb begin
        o_emit     = emit;
        o_emit.one = emit.one && move;
        o_emit.two = emit.two && move;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= bltc_pkg::DIR_ENCODE;
            r_pend0 <= 8'h00;
            r_pend1 <= 8'h00;
            r_width <= 3'd0;
            r_seen  <= 3'd0;
            r_disc  <= 1'b0;
        end else if (i_cfg_we) begin
            r_dir   <= bltc_pkg::t_dir'(i_cfg_wdata);
            r_pend0 <= 8'h00;
            r_pend1 <= 8'h00;
            r_width <= 3'd0;
            r_seen  <= 3'd0;
            r_disc  <= 1'b0;
        end else if (move) begin
            r_pend0 <= n_pend0;
            r_pend1 <= n_pend1;
            r_width <= n_width;
            r_seen  <= n_seen;
            r_disc  <= n_disc;
        end
    end

endmodule

@@ src/bltc_out_buf.sv @@
`timescale 1ns / 1ps

module bltc_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bltc_pkg::t_emit   i_emit,
    output logic              o_slot_free,
    bltc_out_if.source        o_out
);

    logic                r_o_valid;
    bltc_pkg::t_result   r_o;
    logic                r_o2_valid;
    bltc_pkg::t_result   r_o2;
    logic                xfer;

    assign xfer        = r_o_valid && o_out.ready;
    assign o_slot_free = !r_o_valid || (o_out.ready && !r_o2_valid);

    assign o_out.valid     = r_o_valid;
    assign o_out.out_byte  = r_o.out_byte;
    assign o_out.run_last  = r_o.run_last;
    assign o_out.text_last = r_o.text_last;
    assign o_out.status    = r_o.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_o2_valid <= 1'b0;
        end else if (i_emit.one) begin
            r_o_valid  <= 1'b1;
            r_o2_valid <= i_emit.two;
        end else if (xfer) begin
            r_o_valid  <= r_o2_valid;
            r_o2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.one) begin
            r_o  <= i_emit.r0;
            r_o2 <= i_emit.r1;
        end else if (xfer && r_o2_valid) begin
            r_o <= r_o2;
        end
    end

endmodule

@@ src/byte_level_token_text_codec.sv @@
`timescale 1ns / 1ps

// Byte-level token text codec. Write i_cfg_wdata with i_cfg_we to pick encode (0) or
// decode (1); the write also clears any partial character and the discard state, so
// change direction only between texts. Each input byte is registered, translated and
// placed in the result register. One result leaves per cycle while the receiver is
// ready: a byte that encodes to a single byte or a decode byte sustains one input per
// cycle, a byte that encodes to two result bytes fills the two-entry result register,
// so the next translated byte waits until the first of the two has left. Decode bytes
// that only extend a character produce no result. After an error result the rest of the
// text up to the byte marked last is dropped.
module byte_level_token_text_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    bltc_in_if.sink     i_in,
    bltc_out_if.source  o_out
);

    bltc_pkg::t_emit emit;
    logic            slot_free;

    bltc_xlate u_xlate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_slot_free (slot_free),
        .o_emit      (emit)
    );

    bltc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .o_slot_free (slot_free),
        .o_out       (o_out)
    );

endmodule

@@ sim/tb_byte_level_token_text_codec.sv @@
`timescale 1ns / 1ps

module tb_byte_level_token_text_codec;
    import bltc_pkg::*;

    typedef struct packed {
        logic       typed;
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_item_exp;

    typedef struct packed {
        logic       rewrite;
        t_dir       dir;
        logic [7:0] b;
        logic       l;
        t_item_exp  e;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    bltc_in_if  u_in_if ();
    bltc_out_if u_out_if ();

    byte_level_token_text_codec u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (u_in_if),
        .o_out       (u_out_if)
    );

    always #10 i_clk = ~i_clk;

    // codec state mirror
    t_dir       model_dir;
    logic [7:0] col_buf [3];
    logic [2:0] col_width;
    logic [2:0] col_count;
    logic       dropping;

    t_result    token_q [$];
    t_item_exp  item_q [$];
    t_stim_row  stim_rows [$];
    int         mismatches = 0;
    int         live_items = 0;
    int         burst_left = 0;
    t_dir       stim_dir;

    int         pred_n;
    t_result    pred_r0;
    t_result    pred_r1;
    t_result    got;
    t_result    want;
    t_item_exp  cur_item;

    int         stall_mode = 0;
    int         mode_left = 0;
    int         stall_tick = 0;

    function automatic t_result mk_res(input logic [7:0] ob, input logic rl, input logic tl,
                                       input t_status st);
        t_result r;
        r.out_byte  = ob;
        r.run_last  = rl;
        r.text_last = tl;
        r.status    = st;
        return r;
    endfunction

    function automatic logic is_identity(input logic [7:0] b);
        return (b >= 8'h21 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hAC) || (b >= 8'hAE);
    endfunction

    function automatic logic [8:0] raw_to_point(input logic [7:0] b);
        logic [8:0] w;
        w = {1'b0, b};
        if (is_identity(b)) return w;
        if (b <= 8'h20) return 9'h100 + w;
        if (b <= 8'hA0) return 9'h100 + (w - 9'h05E);
        return 9'h143;
    endfunction

    function automatic logic [2:0] utf8_width(input logic [7:0] lead);
        casez (lead)
            8'b0???????: return 3'd1;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            default:     return 3'd4;
        endcase
    endfunction

    function automatic void clear_char();
        col_buf[0] = 8'h00;
        col_buf[1] = 8'h00;
        col_buf[2] = 8'h00;
        col_width  = 3'd0;
        col_count  = 3'd0;
    endfunction

    function automatic void model_config(input t_dir d);
        model_dir = d;
        dropping  = 1'b0;
        clear_char();
    endfunction

    function automatic logic char_to_raw(output logic [7:0] ob);
        logic [10:0] cp;
        logic [6:0]  idx;
        ob = 8'h00;
        if (col_width == 3'd1) begin
            ob = col_buf[0];
            return is_identity(col_buf[0]);
        end
        if (col_width != 3'd2 || col_buf[1][7:6] != 2'b10) return 1'b0;
        cp = {col_buf[0][4:0], col_buf[1][5:0]};
        if (cp >= 11'h080 && cp <= 11'h0FF) begin
            ob = cp[7:0];
            return is_identity(cp[7:0]);
        end
        if (cp >= 11'h100 && cp <= 11'h143) begin
            idx = cp[6:0];
            if (idx <= 7'd32) begin
                ob = {1'b0, idx};
            end else if (idx <= 7'd66) begin
                ob = {1'b0, idx} + 8'h5E;
            end else begin
                ob = 8'hAD;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void codec_step(input logic [7:0] b, input logic l, output int n,
                                       output t_result r0, output t_result r1);
        logic [8:0] cp;
        logic [7:0] ob;
        logic       ok;
        n  = 0;
        r0 = '0;
        r1 = '0;
        cp = raw_to_point(b);
        if (model_dir == DIR_ENCODE) begin
            if (cp < 9'h080) begin
                n  = 1;
                r0 = mk_res(cp[7:0], 1'b1, l, ST_OK);
            end else begin
                n  = 2;
                r0 = mk_res({5'b11000, cp[8:6]}, 1'b0, 1'b0, ST_OK);
                r1 = mk_res({2'b10, cp[5:0]}, 1'b1, l, ST_OK);
            end
            return;
        end
        if (dropping) begin
            if (l) dropping = 1'b0;
            return;
        end
        if (col_count == 3'd0) col_width = utf8_width(b);
        if (col_count < 3'd3) col_buf[col_count[1:0]] = b;
        col_count = col_count + 3'd1;
        if (col_count >= col_width) begin
            ok = char_to_raw(ob);
            clear_char();
            n = 1;
            if (ok) begin
                r0 = mk_res(ob, 1'b1, l, ST_OK);
            end else begin
                r0 = mk_res(8'h00, 1'b1, 1'b1, ST_UNMAPPED);
                if (!l) dropping = 1'b1;
            end
        end else if (l) begin
            clear_char();
            n  = 1;
            r0 = mk_res(8'h00, 1'b1, 1'b1, ST_TRUNC);
        end
    endfunction

    function automatic void report(input string what, input t_result e, input t_result g);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: exp byte=%h rl=%b tl=%b st=%0d got byte=%h rl=%b tl=%b st=%0d",
                     $realtime, what, e.out_byte, e.run_last, e.text_last, e.status,
                     g.out_byte, g.run_last, g.text_last, g.status);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_config(DIR_ENCODE);
        end else begin
            if (u_out_if.valid && u_out_if.ready) begin
                got = mk_res(u_out_if.out_byte, u_out_if.run_last, u_out_if.text_last,
                             t_status'(u_out_if.status));
                if (token_q.size() == 0) begin
                    report("unexpected transfer", '0, got);
                end else begin
                    want = token_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                        got.text_last !== want.text_last || got.status !== want.status) begin
                        report("mismatch", want, got);
                    end
                end
            end
            if (i_cfg_we) model_config(t_dir'(i_cfg_wdata));
            if (u_in_if.valid && u_in_if.ready) begin
                cur_item = (item_q.size() != 0) ? item_q.pop_front() : '0;
                if (model_dir == DIR_ENCODE || !dropping) live_items++;
                codec_step(u_in_if.in_byte, u_in_if.in_last, pred_n, pred_r0, pred_r1);
                if (cur_item.typed) begin
                    if (cur_item.n >= 2'd1) token_q.push_back(cur_item.r0);
                    if (cur_item.n == 2'd2) token_q.push_back(cur_item.r1);
                end else begin
                    if (pred_n >= 1) token_q.push_back(pred_r0);
                    if (pred_n == 2) token_q.push_back(pred_r1);
                end
            end
        end
    end

    // receiver: free-running, light random and one-in-three stall patterns
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(32, 256);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
            0:       u_out_if.ready = 1'b1;
            1:       u_out_if.ready = ($urandom_range(0, 3) != 0);
            default: u_out_if.ready = (stall_tick % 3 == 0);
        endcase
    end

    task automatic drive_byte(input logic [7:0] b, input logic l, input t_item_exp e);
        if (burst_left == 0) begin
            u_in_if.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        item_q.push_back(e);
        u_in_if.valid   = 1'b1;
        u_in_if.in_byte = b;
        u_in_if.in_last = l;
        do @(posedge i_clk); while (!u_in_if.ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic write_direction(input t_dir d);
        u_in_if.valid = 1'b0;
        while (token_q.size() != 0 || item_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_wdata = d;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        stim_dir    = d;
    endtask

    function automatic void add_row(input logic rewrite, input t_dir dir, input logic [7:0] b,
                                    input logic l, input logic typed, input logic [1:0] n,
                                    input t_result r0, input t_result r1);
        t_stim_row row;
        row.rewrite  = rewrite;
        row.dir      = dir;
        row.b        = b;
        row.l        = l;
        row.e.typed  = typed;
        row.e.n      = n;
        row.e.r0     = r0;
        row.e.r1     = r1;
        stim_rows.push_back(row);
    endfunction

    // one decode text: mostly well-formed characters, some broken ones
    task automatic send_token_text();
        logic [7:0] txt [$];
        logic [7:0] lead;
        logic [8:0] cp;
        int         nch;
        int         kind;
        txt = {};
        nch = $urandom_range(1, 6);
        for (int k = 0; k < nch; k++) begin
            kind = $urandom_range(0, 19);
            if (kind < 16) begin
                cp = raw_to_point(8'($urandom_range(0, 255)));
                if (cp < 9'h080) begin
                    txt.push_back(cp[7:0]);
                end else begin
                    txt.push_back({5'b11000, cp[8:6]});
                    txt.push_back({2'b10, cp[5:0]});
                end
            end else if (kind == 16) begin
                txt.push_back(8'($urandom_range(0, 255)));
            end else if (kind == 17) begin
                lead = 8'($urandom_range(8'hE0, 8'hFF));
                txt.push_back(lead);
                repeat (utf8_width(lead) - 1) txt.push_back(8'($urandom_range(0, 255)));
            end else if (kind == 18) begin
                txt.push_back(8'($urandom_range(8'hC0, 8'hC5)));
                txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else begin
                txt.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                txt.push_back(8'($urandom_range(8'h00, 8'h7F)));
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            lead = 8'($urandom_range(8'hC2, 8'hF7));
            txt.push_back(lead);
            if (lead >= 8'hE0 && $urandom_range(0, 1)) begin
                txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        end
        foreach (txt[i]) drive_byte(txt[i], i == txt.size() - 1, '0);
    endtask

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int goal;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        u_in_if.valid   = 1'b0;
        u_in_if.in_byte = 8'h00;
        u_in_if.in_last = 1'b0;
        stim_dir        = DIR_ENCODE;

        // encode
        add_row(0, DIR_ENCODE, 8'h00, 0, 1, 2, mk_res(8'hC4, 0, 0, ST_OK),
                mk_res(8'h80, 1, 0, ST_OK));
        add_row(0, DIR_ENCODE, 8'hFF, 1, 1, 2, mk_res(8'hC3, 0, 0, ST_OK),
                mk_res(8'hBF, 1, 1, ST_OK));
        add_row(0, DIR_ENCODE, 8'h41, 0, 1, 1, mk_res(8'h41, 1, 0, ST_OK), '0);
        add_row(0, DIR_ENCODE, 8'hAD, 1, 1, 2, mk_res(8'hC5, 0, 0, ST_OK),
                mk_res(8'h83, 1, 1, ST_OK));
        add_row(0, DIR_ENCODE, 8'h7F, 0, 0, 0, '0, '0);
        // decode: plain, unmapped single byte then discard to end of text
        add_row(0, DIR_DECODE, 8'h41, 1, 1, 1, mk_res(8'h41, 1, 1, ST_OK), '0);
        add_row(0, DIR_DECODE, 8'h20, 0, 1, 1, mk_res(8'h00, 1, 1, ST_UNMAPPED), '0);
        add_row(0, DIR_DECODE, 8'h41, 0, 1, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h42, 1, 1, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'hC4, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h80, 1, 0, 0, '0, '0);
        // truncated character
        add_row(0, DIR_DECODE, 8'hC3, 1, 1, 1, mk_res(8'h00, 1, 1, ST_TRUNC), '0);
        // overlong form
        add_row(0, DIR_DECODE, 8'hC1, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h81, 1, 0, 0, '0, '0);
        // bad continuation
        add_row(0, DIR_DECODE, 8'hC3, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h41, 1, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'hC5, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h83, 0, 0, 0, '0, '0);
        // three-byte and four-byte characters
        add_row(0, DIR_DECODE, 8'hE2, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h82, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'hAC, 1, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'hFF, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h80, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h80, 0, 0, 0, '0, '0);
        add_row(0, DIR_DECODE, 8'h80, 1, 0, 0, '0, '0);
        // direction write drops a partial character
        add_row(0, DIR_DECODE, 8'hC4, 0, 0, 0, '0, '0);
        add_row(1, DIR_DECODE, 8'h41, 1, 1, 1, mk_res(8'h41, 1, 1, ST_OK), '0);

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_direction(DIR_ENCODE);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].rewrite || stim_rows[i].dir != stim_dir) begin
                write_direction(stim_rows[i].dir);
            end
            drive_byte(stim_rows[i].b, stim_rows[i].l, stim_rows[i].e);
        end

        for (int p = 0; p < 6; p++) begin
            write_direction((p % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
            goal = live_items + 183;
            while (live_items < goal) begin
                if (stim_dir == DIR_ENCODE) begin
                    drive_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, '0);
                end else begin
                    send_token_text();
                end
            end
        end

        u_in_if.valid = 1'b0;
        while (token_q.size() != 0 || item_q.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (mismatches == 0 && token_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
